>>> design/cpfd_pkg.sv
// shared types and constants of the chained pointer fixup decoder
package cpfd_pkg;

  localparam int WordW = 64;
  localparam int OffsetW = 15;
  localparam int OrdinalW = 24;
  localparam int CfgIndexW = 2;

  // register indexes
  localparam logic [CfgIndexW-1:0] CFG_FORMAT_CODE    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_ACTUAL_BASE    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_PREFERRED_BASE = 2'd2;

  // operations
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // pointer format codes
  localparam logic [3:0] FMT_ARM64E         = 4'd1;
  localparam logic [3:0] FMT_GENERIC64      = 4'd2;
  localparam logic [3:0] FMT_GENERIC64_OFFS = 4'd6;
  localparam logic [3:0] FMT_ARM64E_ORD24   = 4'd12;
  localparam logic [3:0] FMT_RESET          = FMT_GENERIC64;

  // arm64e word kinds, top two bits
  localparam logic [1:0] KIND_REBASE      = 2'd0;
  localparam logic [1:0] KIND_BIND        = 2'd1;
  localparam logic [1:0] KIND_AUTH_REBASE = 2'd2;
  localparam logic [1:0] KIND_AUTH_BIND   = 2'd3;

  // first adder operand select
  localparam logic [1:0] SEL_ZERO   = 2'd0;
  localparam logic [1:0] SEL_ACTUAL = 2'd1;
  localparam logic [1:0] SEL_SLIDE  = 2'd2;
  localparam logic [1:0] SEL_TABLE  = 2'd3;

  localparam logic [WordW-1:0] ADDEND_SIGN_MASK = 64'hfffffffffff80000;

  typedef struct packed {
    logic [OffsetW-1:0] next_offset;
    logic               chain_end;
    logic               needs_signing;
    logic [1:0]         sign_key;
    logic [15:0]        sign_diversity;
    logic               address_diversity;
    logic               ordinal_error;
  } side_t;

endpackage

>>> design/chained_pointer_fixup_decoder.sv
// chained pointer fixup decoder top level
// Takes one beat per clock cycle while the output is not stalled and returns one result beat
// per input beat. Stage one decodes the word and reads the bound table (one read port,
// one write port, read data registered), stage two selects the adder operands and stage
// three does the single 64-bit add into the output register. A load beat writes the table
// when it is accepted and returns an all-zero result. The table has no reset: a bind that
// reads an entry never loaded returns an undefined value. A stalled output holds the whole
// pipeline, so the input is stalled only while a finished result waits and is not taken.
module chained_pointer_fixup_decoder #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [cpfd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [cpfd_pkg::WordW-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [63:0]                  slot_word,
  input  logic [11:0]                  table_index,
  input  logic [63:0]                  table_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [63:0]                  fixed_word,
  output logic [14:0]                  next_offset,
  output logic                         chain_end,
  output logic                         needs_signing,
  output logic [1:0]                   sign_key,
  output logic [15:0]                  sign_diversity,
  output logic                         address_diversity,
  output logic                         ordinal_error
);
  import cpfd_pkg::*;

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [OrdinalW:0] DepthLimit = (OrdinalW + 1)'(TABLE_DEPTH);

  // configuration
  logic [3:0]       fmt_code;
  logic [WordW-1:0] actual_base;
  logic [WordW-1:0] preferred_base;
  logic [WordW-1:0] slide;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_code <= FMT_RESET;
      actual_base <= '0;
      preferred_base <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FORMAT_CODE:    fmt_code <= cfg_data[3:0];
        CFG_ACTUAL_BASE:    actual_base <= cfg_data;
        CFG_PREFERRED_BASE: preferred_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slide <= actual_base - preferred_base;
  end

  // pipeline advance
  logic adv;
  logic accept;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept = in_valid && adv;

  // stage one decode
  logic             generic;
  logic [1:0]       kind;
  logic             is_bind;
  logic             is_sign;
  logic [OrdinalW-1:0] ordinal;
  logic             ord_err;
  logic [1:0]       sel_d;
  logic [WordW-1:0] opb_d;
  side_t            side_d;
  logic [OrdinalW-1:0] load_idx;
  logic             load_ok;

  always_comb begin
    generic = (fmt_code == FMT_GENERIC64) || (fmt_code == FMT_GENERIC64_OFFS);
    kind = slot_word[63:62];
    if (generic) begin
      is_bind = slot_word[63];
      is_sign = 1'b0;
      ordinal = slot_word[23:0];
    end else begin
      is_bind = kind[0];
      is_sign = kind[1];
      ordinal = (fmt_code == FMT_ARM64E_ORD24) ? slot_word[23:0]
                                               : {8'b0, slot_word[15:0]};
    end
    ord_err = is_bind && ({1'b0, ordinal} >= DepthLimit);

    side_d = '0;
    if (generic) begin
      side_d.next_offset = {1'b0, slot_word[62:51], 2'b00};
      side_d.chain_end = (slot_word[62:51] == 12'd0);
    end else begin
      side_d.next_offset = {1'b0, slot_word[61:51], 3'b000};
      side_d.chain_end = (slot_word[61:51] == 11'd0);
    end
    if (is_sign) begin
      side_d.needs_signing = 1'b1;
      side_d.sign_diversity = slot_word[47:32];
      side_d.address_diversity = slot_word[48];
      side_d.sign_key = slot_word[50:49];
    end
    side_d.ordinal_error = ord_err;

    sel_d = SEL_ZERO;
    opb_d = '0;
    if (generic) begin
      if (!is_bind) begin
        opb_d = {slot_word[43:36], 20'b0, slot_word[35:0]};
        sel_d = (fmt_code == FMT_GENERIC64_OFFS) ? SEL_ACTUAL : SEL_SLIDE;
      end else begin
        opb_d = {56'b0, slot_word[31:24]};
        sel_d = SEL_TABLE;
      end
    end else begin
      case (kind)
        KIND_REBASE: begin
          opb_d = {slot_word[50:43], 13'b0, slot_word[42:0]};
          sel_d = (fmt_code == FMT_ARM64E) ? SEL_SLIDE : SEL_ACTUAL;
        end
        KIND_BIND: begin
          opb_d = (slot_word[50] ? ADDEND_SIGN_MASK : '0) | {45'b0, slot_word[50:32]};
          sel_d = SEL_TABLE;
        end
        KIND_AUTH_REBASE: begin
          // preferred base plus slide is the actual base
          opb_d = {32'b0, slot_word[31:0]};
          sel_d = SEL_ACTUAL;
        end
        KIND_AUTH_BIND: begin
          opb_d = '0;
          sel_d = SEL_TABLE;
        end
        default: begin
          opb_d = '0;
          sel_d = SEL_ZERO;
        end
      endcase
    end
    if (ord_err) begin
      opb_d = '0;
      sel_d = SEL_ZERO;
    end
    if (operation == OP_LOAD) begin
      opb_d = '0;
      sel_d = SEL_ZERO;
      side_d = '0;
    end

    load_idx = {12'b0, table_index};
    load_ok = ({1'b0, load_idx} < DepthLimit);
  end

  // bound table
  logic [WordW-1:0] bound_table [TABLE_DEPTH];
  logic [WordW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD && load_ok) begin
      bound_table[load_idx[AddrW-1:0]] <= table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && operation == OP_DECODE) begin
      rdata <= bound_table[ordinal[AddrW-1:0]];
    end
  end

  // stage one registers
  logic             v1;
  logic [1:0]       sel1;
  logic [WordW-1:0] opb1;
  side_t            side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel1 <= sel_d;
      opb1 <= opb_d;
      side1 <= side_d;
    end
  end

  // stage two operand select
  logic             v2;
  logic [WordW-1:0] opa2;
  logic [WordW-1:0] opb2;
  side_t            side2;
  logic [WordW-1:0] opa_next;

  always_comb begin
    case (sel1)
      SEL_ZERO:   opa_next = '0;
      SEL_ACTUAL: opa_next = actual_base;
      SEL_SLIDE:  opa_next = slide;
      SEL_TABLE:  opa_next = rdata;
      default:    opa_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opa2 <= opa_next;
      opb2 <= opb1;
      side2 <= side1;
    end
  end

  // stage three add into the output register
  side_t side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fixed_word <= opa2 + opb2;
      side3 <= side2;
    end
  end

  assign next_offset = side3.next_offset;
  assign chain_end = side3.chain_end;
  assign needs_signing = side3.needs_signing;
  assign sign_key = side3.sign_key;
  assign sign_diversity = side3.sign_diversity;
  assign address_diversity = side3.address_diversity;
  assign ordinal_error = side3.ordinal_error;

endmodule
